### rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

   localparam int unsigned BOOK_DEPTH_DEF = 16;
   localparam int unsigned ID_W    = 32;
   localparam int unsigned PRICE_W = 32;
   localparam int unsigned VOL_W   = 24;
   localparam int unsigned KIND_W  = 2;

   localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [VOL_W-1:0]   vol;
      logic [ID_W-1:0]    id;
   } entry_type;

endpackage

### rtl/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Keeps sorted bid and ask books, inserts each accepted order and reports the trades.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// req_     in   tuser side, tdata id/limit_price/quantity
// rsp_     out  tuser kind, tdata ids/volume/price, tlast on final item
//
// A rejected order goes straight to its response. Otherwise the insert position
// is found by a scan of one entry per cycle, then the order is inserted and each
// trade passes through the MATCH and WAIT_M states.
// Output stalls hold the block. Reset empties both books; no clearing pass.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
   parameter int unsigned BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [87:0]   req_tdata,  // id, limit_price, quantity
   input  logic          req_tuser,  // side
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,  // buy_order_id, sell_order_id, trade_volume, trade_price
   output logic [1:0]    rsp_tuser,  // kind
   output logic          rsp_tlast
);

   localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
   localparam int unsigned IW = $clog2(BOOK_DEPTH);
   localparam int unsigned TW = lobm_pkg::VOL_W + CW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_INSERT, ST_MATCH, ST_WAIT_M, ST_WAIT_S
   } state_type;

   state_type state_ff, state_in;
   lobm_pkg::entry_type bid_ff [BOOK_DEPTH];
   lobm_pkg::entry_type bid_in [BOOK_DEPTH];
   lobm_pkg::entry_type ask_ff [BOOK_DEPTH];
   lobm_pkg::entry_type ask_in [BOOK_DEPTH];
   logic [CW-1:0] bid_cnt_ff, bid_cnt_in, ask_cnt_ff, ask_cnt_in;
   logic [CW-1:0] pos_ff, pos_in, n_ff, n_in;
   logic [TW-1:0] traded_ff, traded_in;
   logic          side_ff, side_in;
   lobm_pkg::entry_type ord_ff, ord_in;
   logic [119:0]  out_data_ff, out_data_in;
   logic [1:0]    out_kind_ff, out_kind_in;
   logic          out_last_ff, out_last_in;

   lobm_pkg::entry_type scan_e;
   logic [CW-1:0]       own_cnt;
   logic [lobm_pkg::VOL_W-1:0] v;
   logic [TW-1:0]       qty_x;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_WAIT_M) || (state_ff == ST_WAIT_S);
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in    = state_ff;
      bid_in      = bid_ff;
      ask_in      = ask_ff;
      bid_cnt_in  = bid_cnt_ff;
      ask_cnt_in  = ask_cnt_ff;
      pos_in      = pos_ff;
      n_in        = n_ff;
      traded_in   = traded_ff;
      side_in     = side_ff;
      ord_in      = ord_ff;
      out_data_in = out_data_ff;
      out_kind_in = out_kind_ff;
      out_last_in = out_last_ff;
      own_cnt     = (side_ff == lobm_pkg::SIDE_SELL) ? ask_cnt_ff : bid_cnt_ff;
      scan_e      = (side_ff == lobm_pkg::SIDE_SELL) ? ask_ff[pos_ff[IW-1:0]]
                                                      : bid_ff[pos_ff[IW-1:0]];
      v           = (bid_ff[0].vol < ask_ff[0].vol) ? bid_ff[0].vol : ask_ff[0].vol;
      qty_x       = {{CW{1'b0}}, ord_ff.vol};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               side_in      = req_tuser;
               ord_in.id    = req_tdata[31:0];
               ord_in.price = req_tdata[63:32];
               ord_in.vol   = req_tdata[87:64];
               pos_in       = '0;
               n_in         = '0;
               traded_in    = '0;
               if (req_tdata[87:64] == '0 ||
                   ((req_tuser == lobm_pkg::SIDE_SELL) ? ask_cnt_ff : bid_cnt_ff) >=
                   CW'(BOOK_DEPTH)) begin
                  out_kind_in = lobm_pkg::KIND_REJECT;
                  out_data_in = {32'd0, 24'd0, req_tdata[31:0], req_tdata[31:0]};
                  out_last_in = 1'b1;
                  state_in    = ST_WAIT_S;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (pos_ff == own_cnt ||
                ((side_ff == lobm_pkg::SIDE_SELL) ? (scan_e.price > ord_ff.price)
                                                  : (scan_e.price < ord_ff.price))) begin
               state_in = ST_INSERT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_INSERT: begin
            for (int i = 0; i < BOOK_DEPTH; i++) begin
               if (side_ff == lobm_pkg::SIDE_SELL) begin
                  if (CW'(i) == pos_ff) ask_in[i] = ord_ff;
                  else if (i > 0 && CW'(i) > pos_ff && CW'(i) <= ask_cnt_ff)
                     ask_in[i] = ask_ff[(i > 0) ? i - 1 : 0];
               end else begin
                  if (CW'(i) == pos_ff) bid_in[i] = ord_ff;
                  else if (i > 0 && CW'(i) > pos_ff && CW'(i) <= bid_cnt_ff)
                     bid_in[i] = bid_ff[(i > 0) ? i - 1 : 0];
               end
            end
            if (side_ff == lobm_pkg::SIDE_SELL) ask_cnt_in = ask_cnt_ff + 1'b1;
            else bid_cnt_in = bid_cnt_ff + 1'b1;
            state_in = ST_MATCH;
         end
         ST_MATCH: begin
            if (bid_cnt_ff != '0 && ask_cnt_ff != '0 && n_ff < CW'(BOOK_DEPTH) &&
                bid_ff[0].price >= ask_ff[0].price) begin
               out_kind_in   = lobm_pkg::KIND_MATCH;
               out_data_in   = {ask_ff[0].price, v, ask_ff[0].id, bid_ff[0].id};
               out_last_in   = 1'b0;
               bid_in[0].vol = bid_ff[0].vol - v;
               ask_in[0].vol = ask_ff[0].vol - v;
               traded_in     = traded_ff + TW'(v);
               n_in          = n_ff + 1'b1;
               state_in      = ST_WAIT_M;
            end else begin
               out_kind_in = lobm_pkg::KIND_ACCEPT;
               out_data_in = {32'd0,
                              (traded_ff <= qty_x) ? 24'(qty_x - traded_ff) : 24'd0,
                              ord_ff.id, ord_ff.id};
               out_last_in = 1'b1;
               state_in    = ST_WAIT_S;
            end
         end
         ST_WAIT_M: begin
            if (rsp_tready) begin
               if (bid_ff[0].vol == '0) begin
                  for (int i = 0; i + 1 < BOOK_DEPTH; i++) bid_in[i] = bid_ff[i + 1];
                  bid_cnt_in = bid_cnt_ff - 1'b1;
               end
               if (ask_ff[0].vol == '0) begin
                  for (int i = 0; i + 1 < BOOK_DEPTH; i++) ask_in[i] = ask_ff[i + 1];
                  ask_cnt_in = ask_cnt_ff - 1'b1;
               end
               state_in = ST_MATCH;
            end
         end
         ST_WAIT_S: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      bid_ff      <= bid_in;
      ask_ff      <= ask_in;
      pos_ff      <= pos_in;
      n_ff        <= n_in;
      traded_ff   <= traded_in;
      side_ff     <= side_in;
      ord_ff      <= ord_in;
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         bid_cnt_ff <= '0;
         ask_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bid_cnt_ff <= bid_cnt_in;
         ask_cnt_ff <= ask_cnt_in;
      end
   end

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while result pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bid_cnt_ff <= CW'(BOOK_DEPTH) && ask_cnt_ff <= CW'(BOOK_DEPTH))
      else $error("book count out of range");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not idle after final item");
   a_match_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lobm_pkg::KIND_MATCH |-> !rsp_tlast)
      else $error("match item marked last");
`endif

endmodule
